@@ rtl/cscan_pkg.sv @@
// ----------------------------------------------------------------------------
// cscan_pkg
// Shared types, codes and helpers for the C-SCAN disk head scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cscan_pkg;

   localparam int CYL_W       = 16;
   localparam int MOVED_W     = 18;
   localparam int TOTAL_W     = 32;
   localparam int CSR_IDX_W   = 8;
   localparam int RSP_DATA_W  = 72;   // 16 + 18 + 32 + 1 = 67, padded to bytes
   localparam int RSP_USED_W  = CYL_W + MOVED_W + TOTAL_W + 1;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_START_HEAD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LOW_END    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_END   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION  = CSR_IDX_W'(3);

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_SERVE = 1'b1;

   localparam logic DIR_UP   = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_CALC,
      ST_SUM,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic             any;
      logic             ahead;
      logic [CYL_W-1:0] best;
      logic [CYL_W-1:0] best_dist;
      logic [CYL_W-1:0] extreme;
   } scan_result_type;

   function automatic logic [CYL_W-1:0] absdiff(input logic [CYL_W-1:0] a,
                                                input logic [CYL_W-1:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

@@ rtl/cscan_ram.sv @@
// ----------------------------------------------------------------------------
// cscan_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cscan_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/cscan_scan.sv @@
// ----------------------------------------------------------------------------
// cscan_scan
// Walks the request table one entry a cycle, tracking nearest-ahead and
// wrap-target cylinders plus masks of entries that hold them.
// ----------------------------------------------------------------------------
`default_nettype none

module cscan_scan
   import cscan_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [CYL_W-1:0]               head,
   input  wire logic                           direction,
   input  wire logic [TABLE_DEPTH-1:0]         entry_valid,
   output logic                                rd_en,
   output logic      [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   input  wire logic [CYL_W-1:0]               rd_data,
   output logic                                done,
   output scan_result_type                     result,
   output logic      [TABLE_DEPTH-1:0]         best_mask,
   output logic      [TABLE_DEPTH-1:0]         extreme_mask
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   logic             issue_ff, issue_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             proc_ff;
   logic [IDX_W-1:0] proc_idx_ff;

   scan_result_type        res_ff, res_in;
   logic [TABLE_DEPTH-1:0] bmask_ff, bmask_in;
   logic [TABLE_DEPTH-1:0] emask_ff, emask_in;

   logic                   hit;
   logic [CYL_W-1:0]       cyl;
   logic                   is_ahead;
   logic [CYL_W-1:0]       seek_dist;
   logic [TABLE_DEPTH-1:0] onehot;

   // read issue
   always_comb begin
      issue_in = issue_ff;
      idx_in   = idx_ff;
      if (start) begin
         issue_in = 1'b1;
         idx_in   = '0;
      end else if (issue_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end
      end
   end

   assign rd_en   = issue_ff;
   assign rd_addr = idx_ff;
   assign done    = proc_ff && (proc_idx_ff == LAST_IDX);

   // compare the word read last cycle
   assign hit       = proc_ff && entry_valid[proc_idx_ff];
   assign cyl       = rd_data;
   assign is_ahead  = (direction == DIR_UP) ? (cyl > head) : (cyl < head);
   assign seek_dist = absdiff(cyl, head);
   assign onehot    = TABLE_DEPTH'(1) << proc_idx_ff;

   always_comb begin
      res_in   = res_ff;
      bmask_in = bmask_ff;
      emask_in = emask_ff;
      if (start) begin
         res_in.any   = 1'b0;
         res_in.ahead = 1'b0;
         bmask_in     = '0;
         emask_in     = '0;
      end else if (hit) begin
         // wrap target: lowest (up) or highest (down) pending cylinder
         if (!res_ff.any ||
             ((direction == DIR_UP) ? (cyl < res_ff.extreme) : (cyl > res_ff.extreme))) begin
            res_in.any     = 1'b1;
            res_in.extreme = cyl;
            emask_in       = onehot;
         end else if (cyl == res_ff.extreme) begin
            emask_in = emask_ff | onehot;
         end
         // nearest strictly ahead
         if (is_ahead) begin
            if (!res_ff.ahead || (seek_dist < res_ff.best_dist)) begin
               res_in.ahead     = 1'b1;
               res_in.best      = cyl;
               res_in.best_dist = seek_dist;
               bmask_in         = onehot;
            end else if (cyl == res_ff.best) begin
               bmask_in = bmask_ff | onehot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         proc_ff  <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         proc_ff  <= issue_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      proc_idx_ff <= idx_ff;
      res_ff      <= res_in;
      bmask_ff    <= bmask_in;
      emask_ff    <= emask_in;
   end

   assign result       = res_ff;
   assign best_mask    = bmask_ff;
   assign extreme_mask = emask_ff;

endmodule

`default_nettype wire

@@ rtl/cscan_disk_scheduler.sv @@
// ----------------------------------------------------------------------------
// cscan_disk_scheduler
// C-SCAN disk head scheduler: request table in RAM, head position, total seek.
// ----------------------------------------------------------------------------
// Add word: the ADD state registers the result once the result slot is free.
// Service word: the one-entry-per-cycle table scan, then the CALC, SUM and COMMIT
//   states; COMMIT registers the result once the result slot is free.
// One word in flight at a time; a new word is taken while a result waits.
// Reset (synchronous, active high): table empty, head 0, span 0..65535,
//   direction up, total 0. No clearing pass; valid bits are flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module cscan_disk_scheduler
   import cscan_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [CYL_W-1:0]      req_tdata,   // [15:0] cylinder
   input  wire logic [0:0]            req_tuser,   // [0] command

   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] served_cylinder,
                                                   // [33:16] moved,
                                                   // [65:34] total_distance,
                                                   // [66] wrapped, rest zero
   output logic      [1:0]            rsp_tuser,   // [1:0] status

   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CYL_W-1:0]      csr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [CYL_W-1:0] low_ff, high_ff;
   logic             dir_ff;
   logic [CYL_W-1:0] head_ff;
   logic [TOTAL_W-1:0] total_ff;

   logic csr_fire;
   assign csr_ready = 1'b1;       // the user writes only while idle; the block does not enforce it
   assign csr_fire  = csr_valid && csr_ready;

   // ---------------------------------------------------------------------
   // control
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic req_fire, out_free, scan_start, add_fire, commit_fire;
   logic scan_done;

   logic [CYL_W-1:0] cyl_ff;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser[0] == CMD_SERVE) ? ST_SCAN : ST_ADD;
            end
         end
         ST_ADD: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_CALC;
         end
         ST_CALC:   state_in = ST_SUM;
         ST_SUM:    state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = 1'b0;
      scan_start  = 1'b0;
      add_fire    = 1'b0;
      commit_fire = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            scan_start = req_tvalid && (req_tuser[0] == CMD_SERVE);
         end
         ST_ADD:    add_fire    = out_free;
         ST_COMMIT: commit_fire = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cyl_ff <= req_tdata;
      end
   end

   // ---------------------------------------------------------------------
   // request table: cylinders in RAM, valid bits in flops
   // ---------------------------------------------------------------------
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   ram_we;
   logic [IDX_W-1:0]       free_slot;
   logic                   table_full;
   logic                   ram_re;
   logic [IDX_W-1:0]       ram_raddr;
   logic [CYL_W-1:0]       ram_rdata;

   // lowest free entry
   always_comb begin
      free_slot = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_slot = IDX_W'(i);
      end
   end
   assign table_full = &valid_ff;

   logic out_of_range, at_head;
   assign out_of_range = (cyl_ff < low_ff) || (cyl_ff > high_ff);
   assign at_head      = (cyl_ff == head_ff);
   assign ram_we       = add_fire && !out_of_range && !at_head && !table_full;

   cscan_ram #(
      .WIDTH (CYL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_slot),
      .wr_data (cyl_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // table scan
   // ---------------------------------------------------------------------
   scan_result_type        scan_res;
   logic [TABLE_DEPTH-1:0] best_mask, extreme_mask;

   cscan_scan #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .head         (head_ff),
      .direction    (dir_ff),
      .entry_valid  (valid_ff),
      .rd_en        (ram_re),
      .rd_addr      (ram_raddr),
      .rd_data      (ram_rdata),
      .done         (scan_done),
      .result       (scan_res),
      .best_mask    (best_mask),
      .extreme_mask (extreme_mask)
   );

   // ---------------------------------------------------------------------
   // travel: pick target, then sum the legs, then commit
   // ---------------------------------------------------------------------
   logic [CYL_W-1:0]       target_ff;
   logic [TABLE_DEPTH-1:0] clear_ff;
   logic                   wrap_ff;
   logic                   any_ff;
   logic [CYL_W-1:0]       leg1_ff, leg2_ff, leg3_ff;
   logic [MOVED_W-1:0]     moved_ff;

   logic [CYL_W-1:0] far_end, near_end;
   assign far_end  = (dir_ff == DIR_UP) ? high_ff : low_ff;
   assign near_end = (dir_ff == DIR_UP) ? low_ff  : high_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         any_ff <= scan_res.any;
         if (scan_res.ahead) begin
            target_ff <= scan_res.best;
            clear_ff  <= best_mask;
            wrap_ff   <= 1'b0;
            leg1_ff   <= scan_res.best_dist;
            leg2_ff   <= '0;
            leg3_ff   <= '0;
         end else begin
            // sweep to the far end, jump the span, come in to the target
            target_ff <= scan_res.extreme;
            clear_ff  <= extreme_mask;
            wrap_ff   <= 1'b1;
            leg1_ff   <= absdiff(far_end, head_ff);
            leg2_ff   <= absdiff(high_ff, low_ff);
            leg3_ff   <= absdiff(scan_res.extreme, near_end);
         end
      end
      if (state_ff == ST_SUM) begin
         // three 16-bit legs never exceed the 18-bit range
         moved_ff <= MOVED_W'(leg1_ff) + MOVED_W'(leg2_ff) + MOVED_W'(leg3_ff);
      end
   end

   logic [TOTAL_W:0]   total_sum;
   logic [TOTAL_W-1:0] total_sat;
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(moved_ff);
   assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

   // ---------------------------------------------------------------------
   // state registers
   // ---------------------------------------------------------------------
   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[free_slot] = 1'b1;
      end else if (commit_fire && any_ff) begin
         valid_in = valid_ff & ~clear_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         head_ff  <= '0;
         total_ff <= '0;
         low_ff   <= '0;
         high_ff  <= '1;
         dir_ff   <= DIR_UP;
      end else begin
         valid_ff <= valid_in;
         if (commit_fire && any_ff) begin
            head_ff  <= target_ff;
            total_ff <= total_sat;
         end
         if (csr_fire) begin
            case (csr_index)
               REG_START_HEAD: head_ff <= csr_data;
               REG_LOW_END:    low_ff  <= csr_data;
               REG_HIGH_END:   high_ff <= csr_data;
               REG_DIRECTION:  dir_ff  <= csr_data[0];
               default: ;      // unknown index: ignored
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   logic               rsp_valid_ff;
   logic [CYL_W-1:0]   rsp_served_ff;
   logic [MOVED_W-1:0] rsp_moved_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_wrap_ff;
   status_type         rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (add_fire || commit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (add_fire) begin
         rsp_served_ff <= '0;
         rsp_moved_ff  <= '0;
         rsp_total_ff  <= total_ff;
         rsp_wrap_ff   <= 1'b0;
         if (out_of_range)    rsp_status_ff <= STATUS_RANGE;
         else if (at_head)    rsp_status_ff <= STATUS_OK;
         else if (table_full) rsp_status_ff <= STATUS_FULL;
         else                 rsp_status_ff <= STATUS_OK;
      end else if (commit_fire) begin
         if (any_ff) begin
            rsp_served_ff <= target_ff;
            rsp_moved_ff  <= moved_ff;
            rsp_total_ff  <= total_sat;
            rsp_wrap_ff   <= wrap_ff;
            rsp_status_ff <= STATUS_OK;
         end else begin
            rsp_served_ff <= '0;
            rsp_moved_ff  <= '0;
            rsp_total_ff  <= total_ff;
            rsp_wrap_ff   <= 1'b0;
            rsp_status_ff <= STATUS_EMPTY;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0), rsp_wrap_ff, rsp_total_ff,
                        rsp_moved_ff, rsp_served_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

@@ dv/cscan_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// cscan_tb_pkg
// Scoreboard for the C-SCAN scheduler bench: tracks the request table, head,
// span and seek total, and holds the words the block owes on its rsp stream.
// ----------------------------------------------------------------------------

package cscan_tb_pkg;

   import cscan_pkg::*;

   localparam int SLOTS       = 16;
   localparam logic DIR_DOWN  = 1'b1;

   localparam logic [MOVED_W-1:0] MOVED_CEIL = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_CEIL = '1;

   typedef struct packed {
      logic [CYL_W-1:0]   cyl;
      logic [MOVED_W-1:0] moved;
      logic [TOTAL_W-1:0] total;
      logic               wrapped;
      status_type         status;
   } served_word_type;

   class seek_scoreboard;

      logic [CYL_W-1:0]   low_end;
      logic [CYL_W-1:0]   high_end;
      logic [CYL_W-1:0]   head;
      logic               direction;
      logic [TOTAL_W-1:0] total;
      logic               slot_used [SLOTS];
      logic [CYL_W-1:0]   slot_cyl [SLOTS];
      served_word_type    owed_q [$];
      int                 errors;

      function new();
         low_end   = '0;
         high_end  = '1;
         head      = '0;
         direction = DIR_UP;
         total     = '0;
         errors    = 0;
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_cyl[i]  = '0;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function int occupancy();
         int count;
         count = 0;
         foreach (slot_used[i]) count += slot_used[i];
         return count;
      endfunction

      function int unsigned seek_gap(logic [CYL_W-1:0] a, logic [CYL_W-1:0] b);
         int unsigned ua;
         int unsigned ub;
         ua = a;
         ub = b;
         return (ua > ub) ? (ua - ub) : (ub - ua);
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CYL_W-1:0] value);
         case (idx)
            REG_START_HEAD: head = value;   // loads the head as well
            REG_LOW_END:    low_end = value;
            REG_HIGH_END:   high_end = value;
            REG_DIRECTION:  direction = value[0];
            default: ;
         endcase
      endfunction

      function void note_request(logic cmd, logic [CYL_W-1:0] cyl);
         served_word_type  w;
         int               free_slot;
         bit               any;
         bit               ahead;
         logic [CYL_W-1:0] best;
         logic [CYL_W-1:0] extreme;
         logic [CYL_W-1:0] far_end;
         logic [CYL_W-1:0] near_end;
         int unsigned      travel;
         logic [TOTAL_W:0] sum;
         w.cyl     = '0;
         w.moved   = '0;
         w.wrapped = 1'b0;
         w.status  = STATUS_OK;
         if (cmd == CMD_ADD) begin
            free_slot = -1;
            if (cyl < low_end || cyl > high_end) begin
               w.status = STATUS_RANGE;
            end else if (cyl != head) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!slot_used[i] && free_slot < 0) free_slot = i;
               end
               if (free_slot < 0) begin
                  w.status = STATUS_FULL;
               end else begin
                  slot_used[free_slot] = 1'b1;
                  slot_cyl[free_slot]  = cyl;
               end
            end
         end else begin
            any     = 0;
            ahead   = 0;
            best    = '0;
            extreme = '0;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i]) begin
                  if (!any) begin
                     extreme = slot_cyl[i];
                     any     = 1;
                  end else if (direction == DIR_UP ? (slot_cyl[i] < extreme)
                                                   : (slot_cyl[i] > extreme)) begin
                     extreme = slot_cyl[i];
                  end
                  if (direction == DIR_UP ? (slot_cyl[i] > head) : (slot_cyl[i] < head)) begin
                     if (!ahead || seek_gap(slot_cyl[i], head) < seek_gap(best, head)) begin
                        best  = slot_cyl[i];
                        ahead = 1;
                     end
                  end
               end
            end
            if (!any) begin
               w.status = STATUS_EMPTY;
            end else begin
               if (ahead) begin
                  travel = seek_gap(best, head);
               end else begin
                  // sweep to the far end, jump across the span, take the first one
                  far_end   = (direction == DIR_UP) ? high_end : low_end;
                  near_end  = (direction == DIR_UP) ? low_end : high_end;
                  best      = extreme;
                  w.wrapped = 1'b1;
                  travel    = seek_gap(far_end, head) + seek_gap(high_end, low_end)
                            + seek_gap(best, near_end);
               end
               if (travel > MOVED_CEIL) travel = MOVED_CEIL;
               sum   = total + travel;
               total = (sum > TOTAL_CEIL) ? TOTAL_CEIL : sum[TOTAL_W-1:0];
               head  = best;
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_used[i] && slot_cyl[i] == best) slot_used[i] = 1'b0;
               end
               w.cyl   = best;
               w.moved = travel[MOVED_W-1:0];
            end
         end
         w.total = total;
         owed_q  = {owed_q, w};
      endfunction

      function void compare_field(time stamp, string label, logic [31:0] want,
                                  logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("[%0d ns] %s mismatch: expected %0d actual %0d",
                     stamp, label, want, got);
         end
      endfunction

      function void check_result(time stamp, logic [RSP_DATA_W-1:0] data, logic [1:0] user);
         served_word_type want;
         if (owed_q.size() == 0) begin
            errors++;
            $display("[%0d ns] unexpected word: expected none actual data %0h status %0d",
                     stamp, data, user);
            return;
         end
         want = owed_q[0];
         owed_q.delete(0);
         compare_field(stamp, "served_cylinder", want.cyl, data[CYL_W-1:0]);
         compare_field(stamp, "moved", want.moved, data[CYL_W +: MOVED_W]);
         compare_field(stamp, "total_distance", want.total, data[CYL_W+MOVED_W +: TOTAL_W]);
         compare_field(stamp, "wrapped", want.wrapped, data[RSP_USED_W-1]);
         compare_field(stamp, "pad bits", '0, data[RSP_DATA_W-1:RSP_USED_W]);
         compare_field(stamp, "status", want.status, user);
      endfunction

   endclass

endpackage

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Bench for the C-SCAN disk head scheduler. A directed opener, random phases
// over several span and direction settings with idle bursts on both streams,
// then a closing round of near-maximum wraps with no idling.
// Every rsp word is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import cscan_pkg::*;
   import cscan_tb_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;   // quiet cycles before giving up
   localparam int RANDOM_PHASES   = 9;
   localparam int WORDS_PER_PHASE = 55;
   localparam int DRAIN_CYCLES    = 32;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CYL_W-1:0]      req_tdata = '0;
   logic [0:0]            req_tuser = '0;

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CYL_W-1:0]      csr_data = '0;

   seek_scoreboard sb = new();

   bit bursts_on = 1'b1;       // idle bursts on both streams
   int rsp_hold  = 0;          // remaining stall cycles on the rsp side
   int quiet     = 0;          // cycles with no handshake at all

   cscan_disk_scheduler #(
      .TABLE_DEPTH (SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // rsp side: ready drops for random bursts while bursts are on
   always @(negedge clock) begin
      if (!bursts_on) begin
         rsp_hold   = 0;
         rsp_tready = 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_hold   = $urandom_range(1, 6) - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // every accepted rsp word is matched against the oldest owed word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result($time, rsp_tdata, rsp_tuser);
   end

   // watchdog: ends the run if no handshake happens for too long
   initial begin
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   // wait until the block owes nothing; it is idle then
   task automatic drain_results();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // one word on the req stream; called and returns at a falling edge
   task automatic send_word(input logic cmd, input logic [CYL_W-1:0] cyl);
      if (bursts_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clock);
      req_tuser  = cmd;
      req_tdata  = cyl;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, cyl);
      @(negedge clock);
      req_tvalid = 1'b0;   // raised again by the next send_word, after any idle burst
   endtask

   // register write, only with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CYL_W-1:0] value);
      drain_results();
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.note_config(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // add targets: mostly in span, with the ends, the head and just-outside values
   function automatic logic [CYL_W-1:0] pick_cylinder();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return CYL_W'($urandom);
      if (r < 18) return sb.low_end;
      if (r < 24) return sb.high_end;
      if (r < 30) return sb.head;
      if (r < 33) return sb.low_end - 1'b1;
      if (r < 36) return sb.high_end + 1'b1;
      if (sb.low_end > sb.high_end) return CYL_W'($urandom);
      return sb.low_end + CYL_W'($urandom_range(0, sb.high_end - sb.low_end));
   endfunction

   task automatic run_phase(input int phase);
      logic [CYL_W-1:0] lo;
      logic [CYL_W-1:0] hi;
      logic             dir;
      logic             cmd;
      int               add_pct;
      case (phase)
         0: begin
            lo  = '0;
            hi  = '1;
            dir = DIR_UP;
         end
         1: begin
            lo  = '0;
            hi  = '1;
            dir = DIR_DOWN;
         end
         2: begin   // tiny span: duplicates, full table, many out of range
            lo  = '0;
            hi  = CYL_W'(15);
            dir = 1'($urandom);
         end
         3: begin
            lo  = CYL_W'(16'hFFF0);
            hi  = '1;
            dir = DIR_DOWN;
         end
         4: begin   // inverted span: every add is out of range
            lo  = CYL_W'($urandom_range(1, 65535));
            hi  = CYL_W'($urandom_range(0, lo - 1));
            dir = 1'($urandom);
         end
         default: begin
            lo  = CYL_W'($urandom_range(0, 62000));
            hi  = lo + CYL_W'($urandom_range(0, 3000));
            dir = 1'($urandom);
         end
      endcase
      add_pct = (phase == 2) ? 85 : (phase == 4) ? 40 : 55 + 10 * (phase % 3);
      write_reg(REG_LOW_END, lo);
      write_reg(REG_HIGH_END, hi);
      write_reg(REG_DIRECTION, {15'($urandom), dir});   // upper bits ignored
      if (phase % 2 == 0)
         write_reg(REG_START_HEAD, (phase == 4) ? CYL_W'($urandom)
                                                : lo + CYL_W'($urandom_range(0, 32)));
      if (phase == 5) write_reg(CSR_IDX_W'($urandom_range(4, 255)), CYL_W'($urandom));
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
         // hold the sender off until the block has answered everything
         if (n == WORDS_PER_PHASE / 2 && phase % 3 == 0) drain_results();
         cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_SERVE;
         send_word(cmd, (cmd == CMD_ADD) ? pick_cylinder() : CYL_W'($urandom));
      end
   endtask

   // Alternating-direction wraps over an inverted span with no idling: each
   // service moves close to the 196605 maximum. The entries are placed with a
   // normal span, then the span is inverted.
   task automatic wide_wraps();
      bursts_on = 1'b0;
      while (sb.occupancy() != 0) send_word(CMD_SERVE, CYL_W'($urandom));
      write_reg(REG_LOW_END, '0);
      write_reg(REG_HIGH_END, '1);
      write_reg(REG_START_HEAD, '1);
      for (int k = 0; k < 8; k++) begin
         send_word(CMD_ADD, CYL_W'(k));
         send_word(CMD_ADD, CYL_W'(65534 - k));
      end
      write_reg(REG_LOW_END, '1);
      write_reg(REG_HIGH_END, '0);
      for (int s = 0; s < SLOTS; s++) begin
         write_reg(REG_DIRECTION, CYL_W'(s[0] ? DIR_DOWN : DIR_UP));
         send_word(CMD_SERVE, CYL_W'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset span 0..65535, head 0, sweep up
      send_word(CMD_SERVE, '1);              // empty table
      send_word(CMD_ADD, '0);                // at the head: served already
      send_word(CMD_ADD, '1);
      send_word(CMD_ADD, CYL_W'(100));
      send_word(CMD_ADD, CYL_W'(100));       // duplicate takes its own slot
      send_word(CMD_SERVE, '0);              // 100, both slots cleared
      send_word(CMD_SERVE, '0);              // 65535
      send_word(CMD_ADD, CYL_W'(50));
      send_word(CMD_SERVE, '0);              // nothing ahead: wrap up to 50

      // narrow span, sweep down, head in the middle
      write_reg(REG_LOW_END, CYL_W'(1000));
      write_reg(REG_HIGH_END, CYL_W'(2000));
      write_reg(REG_DIRECTION, CYL_W'(DIR_DOWN));
      write_reg(REG_START_HEAD, CYL_W'(1500));
      write_reg('1, '1);                     // unknown index, ignored
      send_word(CMD_ADD, CYL_W'(999));       // below span
      send_word(CMD_ADD, CYL_W'(2001));      // above span
      send_word(CMD_ADD, CYL_W'(1000));
      send_word(CMD_ADD, CYL_W'(2000));
      send_word(CMD_ADD, CYL_W'(1200));
      send_word(CMD_ADD, CYL_W'(1500));      // at the head
      send_word(CMD_SERVE, '0);              // 1200
      send_word(CMD_SERVE, '0);              // 1000
      send_word(CMD_SERVE, '0);              // wrap down to 2000

      // low end above high end: nothing is in range
      write_reg(REG_LOW_END, CYL_W'(10));
      write_reg(REG_HIGH_END, CYL_W'(5));
      send_word(CMD_ADD, CYL_W'(7));
      send_word(CMD_ADD, '1);
      send_word(CMD_SERVE, '0);

      for (int p = 0; p < RANDOM_PHASES; p++) run_phase(p);

      wide_wraps();

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cscan_pkg.sv
rtl/cscan_ram.sv
rtl/cscan_scan.sv
rtl/cscan_disk_scheduler.sv
dv/cscan_tb_pkg.sv
dv/tb_top.sv
